>>> rtl/bba_pkg.sv
package bba_pkg;

    // Width of the row read-back word; wider rows show only their low columns.
    localparam int ROW_BITS_W = 16;
    localparam int COL_W      = $clog2(ROW_BITS_W);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_TOOBIG  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] file_name;
        logic [7:0] block_count;
        logic [2:0] row_index;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [7:0]            blocks_done;
        logic [ROW_BITS_W-1:0] row_bits;
    } rsp_t;

    // One memory word per block: used bit, owner-tag valid bit and owner name.
    typedef struct packed {
        logic       used;
        logic       owned;
        logic [7:0] name;
    } entry_t;

endpackage

>>> rtl/bba_req_if.sv
interface bba_req_if;
    logic          valid;
    logic          ready;
    bba_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bba_rsp_if.sv
interface bba_rsp_if;
    logic          valid;
    logic          ready;
    bba_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bitmap_block_allocator.sv
// Bitmap block allocator. The block keeps a ROWS x COLS disk bitmap together
// with an owner name for every block, all in one block-wide synchronous
// memory, and serves one request transaction at a time on the req channel,
// answering with exactly one response transaction on the rsp channel.
// Allocate claims the lowest-numbered free blocks (all or nothing), free
// releases every block tagged with the given name, and read returns the used
// bits of one row. After reset the block runs a clearing pass over every
// block, during which req.ready stays low, and marks row 0 as reserved.
// Operation: the memory is walked one block per cycle through a registered
// read port; free walks all ROWS*COLS blocks, allocate walks up to as many
// (it stops as soon as the last requested block has been claimed), read
// walks min(COLS,16) blocks, and rejected or empty requests skip the walk. A
// pending response does not stop the next request from being accepted.
module bitmap_block_allocator #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    localparam int TOTAL = ROWS * COLS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W = $clog2(TOTAL + 1);
    localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
    localparam int SHOW  = (COLS < ROW_BITS_W) ? COLS : ROW_BITS_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    // Block memory and its registered read port.
    entry_t mem [TOTAL];
    entry_t rd_data_reg;
    logic   mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t mem_wdata;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [7:0]            name_reg, name_next;
    logic [CNT_W-1:0]      want_reg, want_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [COL_W-1:0]      pend_col_reg, pend_col_next;
    logic [CNT_W-1:0]      got_reg, got_next;
    logic [ROW_BITS_W-1:0] bits_reg, bits_next;
    status_t               status_reg, status_next;
    logic [CNT_W-1:0]      free_reg, free_next;
    rsp_t                  rsp_data_reg, rsp_data_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic          more;
    logic          issue;
    logic          hit;
    logic          alloc_full;
    logic          finish;
    logic [CW-1:0] count_ext;
    logic [CW-1:0] free_ext;
    logic          row_ok;
    op_t           req_op;

    assign req_op    = op_t'(req.data.opcode);
    assign count_ext = CW'(req.data.block_count);
    assign free_ext  = CW'(free_reg);
    assign row_ok    = (32'(req.data.row_index) < 32'(ROWS));

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // The scan issues one read per cycle; the word returns through the
    // registered read port and is examined (and possibly rewritten) while
    // the next read is issued. Every address is read once per request, so a
    // write never races a read of the same entry.
    assign more      = (idx_reg < len_reg);
    assign issue     = (state_reg == S_SCAN) && more;
    assign mem_raddr = base_reg + idx_reg[AW-1:0];

    always_comb
    begin
        hit = 1'b0;
        if (pend_reg)
        begin
            unique case (op_reg)
                OP_ALLOC: hit = !rd_data_reg.used && (got_reg < want_reg);
                OP_FREE:  hit = rd_data_reg.owned && (rd_data_reg.name == name_reg);
                OP_READ:  hit = 1'b0;
                OP_NONE:  hit = 1'b0;
                default:  hit = 1'b0;
            endcase
        end
    end

    assign alloc_full = (op_reg == OP_ALLOC) && ((got_reg + CNT_W'(hit)) == want_reg);
    assign finish     = (pend_reg && (!more || alloc_full)) || (!more && !pend_reg);

    // Memory write port: the clearing pass after reset, or a claim or release.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we         = 1'b1;
            mem_waddr      = idx_reg[AW-1:0];
            mem_wdata.used = (idx_reg < CNT_W'(COLS));
        end
        else if ((state_reg == S_SCAN) && hit)
        begin
            mem_we = 1'b1;
            if (op_reg == OP_ALLOC)
            begin
                mem_wdata.used  = 1'b1;
                mem_wdata.owned = 1'b1;
                mem_wdata.name  = name_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        name_next      = name_reg;
        want_next      = want_reg;
        base_next      = base_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_col_next  = pend_col_reg;
        got_next       = got_reg;
        bits_next      = bits_reg;
        status_next    = status_reg;
        free_next      = free_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        unique case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == CNT_W'(TOTAL - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req_op;
                    name_next   = req.data.file_name;
                    want_next   = CNT_W'(count_ext);
                    idx_next    = '0;
                    col_next    = '0;
                    got_next    = '0;
                    bits_next   = '0;
                    status_next = ST_OK;
                    base_next   = '0;
                    len_next    = CNT_W'(TOTAL);
                    state_next  = S_RESULT;
                    unique case (req_op)
                        OP_ALLOC:
                        begin
                            if (count_ext > CW'(TOTAL))
                            begin
                                status_next = ST_TOOBIG;
                            end
                            else if (count_ext > free_ext)
                            begin
                                status_next = ST_NOSPACE;
                            end
                            else if (count_ext != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_READ:
                        begin
                            // A row beyond the bitmap reads as all zero.
                            if (row_ok)
                            begin
                                base_next  = AW'(req.data.row_index) * AW'(COLS);
                                len_next   = CNT_W'(SHOW);
                                state_next = S_SCAN;
                            end
                        end
                        OP_NONE:
                        begin
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    idx_next       = idx_reg + CNT_W'(1);
                    col_next       = col_reg + COL_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = mem_raddr;
                    pend_col_next  = col_reg;
                end
                if (pend_reg && (op_reg == OP_READ))
                begin
                    bits_next[pend_col_reg] = rd_data_reg.used;
                end
                got_next = got_reg + CNT_W'(hit);
                if (finish)
                begin
                    pend_next  = 1'b0;
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                // Load the output register once the previous response has left.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next.status      = status_reg;
                    rsp_data_next.blocks_done = 8'(got_reg);
                    rsp_data_next.row_bits    = bits_reg;
                    rsp_valid_next            = 1'b1;
                    if (op_reg == OP_ALLOC)
                    begin
                        free_next = free_reg - got_reg;
                    end
                    else if (op_reg == OP_FREE)
                    begin
                        free_next = free_reg + got_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            free_reg      <= CNT_W'(TOTAL - COLS);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        name_reg      <= name_next;
        want_reg      <= want_next;
        base_reg      <= base_next;
        len_reg       <= len_next;
        col_reg       <= col_next;
        pend_addr_reg <= pend_addr_next;
        pend_col_reg  <= pend_col_next;
        got_reg       <= got_next;
        bits_reg      <= bits_next;
        status_reg    <= status_next;
        rsp_data_reg  <= rsp_data_next;
    end

endmodule
